[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CHK_NEVER(lbl, expr, msg) `CHK_PROP(lbl, !(expr), msg)
`else
`define CHK_PROP(lbl, prop, msg)
`define CHK_NEVER(lbl, expr, msg)
`endif
`endif

[src/srrw_pkg.sv]
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared types and constants of the selective-repeat receive window.
// ----------------------------------------------------------------------------
`default_nettype none

package srrw_pkg;

	localparam int KIND_W     = 2;
	localparam int SEQ_W      = 32;
	localparam int LEN_W      = 11;
	localparam int TAG_W      = 16;
	localparam int WS_W       = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	// longest payload kept in a slot
	localparam int MAX_PAYLOAD = 1024;

	localparam logic [WS_W-1:0] WS_RESET = 5'd16;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_MODE    = 1'd1;

	typedef enum logic [KIND_W-1:0] {
		PKT_START = 2'd0,
		PKT_END   = 2'd1,
		PKT_DATA  = 2'd2,
		PKT_OTHER = 2'd3
	} pkt_kind_t;

	typedef enum logic [KIND_W-1:0] {
		RES_ACK     = 2'd0,
		RES_DELIVER = 2'd1,
		RES_REJECT  = 2'd2
	} res_kind_t;

	typedef enum logic [2:0] {
		SEL_ACK_SEQ,
		SEL_ACK_MODE,
		SEL_DONE,
		SEL_REJECT,
		SEL_DELIVER
	} res_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     start;
		logic     close;
		logic     store;
		logic     pop;
		logic     load_res;
		res_sel_t sel;
	} ctrl_cmd_t;

	typedef struct packed {
		pkt_kind_t kind;
		logic      good;
		logic      open;
		logic      is_exp;
		logic      in_win;
		logic      below_ack;
		logic      marked;
		logic      can_pop;
	} dp_status_t;

endpackage

`default_nettype wire

[src/srrw_if.sv]
// ----------------------------------------------------------------------------
// srrw_if
// Valid/ready channels: packet descriptors, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface srrw_pkt_if;
	import srrw_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] packet_kind;
	logic              checksum_good;
	logic [SEQ_W-1:0]  sequence_number;
	logic [LEN_W-1:0]  payload_length;
	logic [TAG_W-1:0]  payload_tag;

	modport source (output valid, packet_kind, checksum_good, sequence_number,
		payload_length, payload_tag, input ready);
	modport sink (input valid, packet_kind, checksum_good, sequence_number,
		payload_length, payload_tag, output ready);
endinterface

interface srrw_res_if;
	import srrw_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] result_kind;
	logic [SEQ_W-1:0]  ack_number;
	logic [TAG_W-1:0]  deliver_tag;
	logic [LEN_W-1:0]  deliver_length;
	logic              session_done;
	logic              last_of_run;

	modport source (output valid, result_kind, ack_number, deliver_tag,
		deliver_length, session_done, last_of_run, input ready);
	modport sink (input valid, result_kind, ack_number, deliver_tag,
		deliver_length, session_done, last_of_run, output ready);
endinterface

interface srrw_cfg_if;
	import srrw_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/srrw_ram.sv]
// ----------------------------------------------------------------------------
// srrw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srrw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[src/srrw_dp.sv]
// ----------------------------------------------------------------------------
// srrw_dp
// Datapath: input and config registers, window state, slot store and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module srrw_dp #(
	parameter int WINDOW = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [srrw_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [srrw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [srrw_pkg::KIND_W-1:0]     in_kind,
	input  wire logic                            in_good,
	input  wire logic [srrw_pkg::SEQ_W-1:0]      in_seq,
	input  wire logic [srrw_pkg::LEN_W-1:0]      in_len,
	input  wire logic [srrw_pkg::TAG_W-1:0]      in_tag,
	input  wire srrw_pkg::ctrl_cmd_t             cmd,
	output srrw_pkg::dp_status_t                 sts,
	output logic      [srrw_pkg::KIND_W-1:0]     res_kind,
	output logic      [srrw_pkg::SEQ_W-1:0]      res_ack,
	output logic      [srrw_pkg::TAG_W-1:0]      res_tag,
	output logic      [srrw_pkg::LEN_W-1:0]      res_len,
	output logic                                 res_done
);
	import srrw_pkg::*;

	localparam int PTR_W  = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int CW     = (CNT_W > WS_W) ? CNT_W : WS_W;
	localparam int SLOT_W = LEN_W + TAG_W;

	pkt_kind_t        in_kind_q;
	logic             in_good_q;
	logic [SEQ_W-1:0] in_seq_q;
	logic [LEN_W-1:0] in_len_q;
	logic [TAG_W-1:0] in_tag_q;

	logic [WS_W-1:0]   ws_q;
	logic              mode_q;
	logic              open_q;
	logic [SEQ_W-1:0]  exp_q;
	logic [PTR_W-1:0]  head_q;
	logic [CNT_W-1:0]  run_q;
	logic [WINDOW-1:0] valid_q;

	logic [KIND_W-1:0] res_kind_q;
	logic [SEQ_W-1:0]  res_ack_q;
	logic [TAG_W-1:0]  res_tag_q;
	logic [LEN_W-1:0]  res_len_q;
	logic              res_done_q;

	logic [CW-1:0]      ws_ext;
	logic [CW-1:0]      w_full;
	logic [CNT_W-1:0]   w_eff;
	logic [SEQ_W:0]     win_end;
	logic [SEQ_W-1:0]   lo_bound;
	logic [SEQ_W-1:0]   diff;
	logic [PTR_W:0]     phys_sum;
	logic [PTR_W-1:0]   phys;
	logic [PTR_W-1:0]   head_inc;
	logic [LEN_W-1:0]   len_sat;
	logic [SLOT_W-1:0]  slot_rdata;

	// effective window, clamped to 1..WINDOW
	always_comb begin
		ws_ext = CW'(ws_q);
		if (ws_ext == '0) begin
			w_full = CW'(1);
		end else if (ws_ext > CW'(WINDOW)) begin
			w_full = CW'(WINDOW);
		end else begin
			w_full = ws_ext;
		end
		w_eff = w_full[CNT_W-1:0];
	end

	assign win_end  = {1'b0, exp_q} + (SEQ_W+1)'(w_eff);
	assign lo_bound = (exp_q >= SEQ_W'(w_eff)) ? exp_q - SEQ_W'(w_eff) : '0;
	assign diff     = in_seq_q - exp_q;

	// slot offset to physical entry, modulo WINDOW
	always_comb begin
		phys_sum = {1'b0, head_q} + {1'b0, diff[PTR_W-1:0]};
		if (phys_sum >= (PTR_W+1)'(WINDOW)) begin
			phys_sum = phys_sum - (PTR_W+1)'(WINDOW);
		end
		phys = phys_sum[PTR_W-1:0];
	end

	assign head_inc = (head_q == PTR_W'(WINDOW - 1)) ? '0 : head_q + PTR_W'(1);
	assign len_sat  = (32'(in_len_q) > 32'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : in_len_q;

	always_comb begin
		sts.kind      = in_kind_q;
		sts.good      = in_good_q;
		sts.open      = open_q;
		sts.is_exp    = (in_seq_q == exp_q);
		sts.in_win    = (in_seq_q > exp_q) && ({1'b0, in_seq_q} < win_end);
		sts.below_ack = (in_seq_q < exp_q) && (mode_q || (in_seq_q >= lo_bound));
		sts.marked    = valid_q[phys];
		sts.can_pop   = (run_q < w_eff) && valid_q[head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_kind_q <= pkt_kind_t'(in_kind);
			in_good_q <= in_good;
			in_seq_q  <= in_seq;
			in_len_q  <= in_len;
			in_tag_q  <= in_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q   <= WS_RESET;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WINDOW_SIZE: ws_q   <= cfg_data;
				REG_ACK_MODE:    mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			exp_q   <= '0;
			head_q  <= '0;
			run_q   <= '0;
			valid_q <= '0;
		end else begin
			if (cmd.load_in) begin
				run_q <= '0;
			end
			if (cmd.start) begin
				open_q  <= 1'b1;
				exp_q   <= '0;
				head_q  <= '0;
				valid_q <= '0;
			end
			if (cmd.close) begin
				open_q <= 1'b0;
			end
			if (cmd.store) begin
				valid_q[phys] <= 1'b1;
			end
			// release head slot and slide the window by one
			if (cmd.pop) begin
				valid_q[head_q] <= 1'b0;
				head_q          <= head_inc;
				exp_q           <= exp_q + SEQ_W'(1);
				run_q           <= run_q + CNT_W'(1);
			end
		end
	end

	srrw_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(WINDOW)
	) u_slot_ram (
		.clk  (clk),
		.we   (cmd.store),
		.waddr(phys),
		.wdata({len_sat, in_tag_q}),
		.re   (cmd.pop),
		.raddr(head_q),
		.rdata(slot_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			res_kind_q <= RES_ACK;
			res_ack_q  <= '0;
			res_tag_q  <= '0;
			res_len_q  <= '0;
			res_done_q <= 1'b0;
			case (cmd.sel)
				SEL_ACK_SEQ:  res_ack_q <= in_seq_q;
				SEL_ACK_MODE: res_ack_q <= mode_q ? in_seq_q : exp_q;
				SEL_DONE: begin
					res_ack_q  <= in_seq_q;
					res_done_q <= 1'b1;
				end
				SEL_REJECT:   res_kind_q <= RES_REJECT;
				SEL_DELIVER: begin
					res_kind_q <= RES_DELIVER;
					res_len_q  <= slot_rdata[SLOT_W-1:TAG_W];
					res_tag_q  <= slot_rdata[TAG_W-1:0];
				end
				default: ;
			endcase
		end
	end

	assign res_kind = res_kind_q;
	assign res_ack  = res_ack_q;
	assign res_tag  = res_tag_q;
	assign res_len  = res_len_q;
	assign res_done = res_done_q;

endmodule

`default_nettype wire

[src/srrw_ctrl.sv]
// ----------------------------------------------------------------------------
// srrw_ctrl
// Controller: classifies each descriptor and sequences the in-order release.
// ----------------------------------------------------------------------------
`default_nettype none

module srrw_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      out_last,
	input  wire srrw_pkg::dp_status_t sts,
	output srrw_pkg::ctrl_cmd_t       cmd
);
	import srrw_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLASS,
		S_CHECK,
		S_FETCH,
		S_EMIT
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   last_q, last_n;

	always_comb begin
		cmd          = '0;
		cmd.sel      = SEL_ACK_MODE;
		state_n      = state_q;
		last_n       = last_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_n     = S_CLASS;
				end
			end
			S_CLASS: begin
				state_n = S_IDLE;
				unique case (sts.kind)
					PKT_START: begin
						if (sts.good) begin
							cmd.start    = 1'b1;
							cmd.load_res = 1'b1;
							cmd.sel      = SEL_ACK_SEQ;
							last_n       = 1'b1;
							state_n      = S_EMIT;
						end
					end
					PKT_END, PKT_DATA: begin
						if (!sts.open) begin
							cmd.load_res = 1'b1;
							cmd.sel      = SEL_REJECT;
							last_n       = 1'b1;
							state_n      = S_EMIT;
						end else if (!sts.good) begin
							state_n = S_IDLE;
						end else if (sts.kind == PKT_END) begin
							cmd.close    = 1'b1;
							cmd.load_res = 1'b1;
							cmd.sel      = SEL_DONE;
							last_n       = 1'b1;
							state_n      = S_EMIT;
						end else if (sts.is_exp) begin
							// overwrite head slot, then walk the run
							cmd.store = 1'b1;
							state_n   = S_CHECK;
						end else if (sts.in_win || sts.below_ack) begin
							cmd.store    = sts.in_win && !sts.marked;
							cmd.load_res = 1'b1;
							cmd.sel      = SEL_ACK_MODE;
							last_n       = 1'b1;
							state_n      = S_EMIT;
						end
					end
					default: state_n = S_IDLE;
				endcase
			end
			S_CHECK: begin
				if (sts.can_pop) begin
					cmd.pop = 1'b1;
					state_n = S_FETCH;
				end else begin
					cmd.load_res = 1'b1;
					cmd.sel      = SEL_ACK_MODE;
					last_n       = 1'b1;
					state_n      = S_EMIT;
				end
			end
			S_FETCH: begin
				cmd.load_res = 1'b1;
				cmd.sel      = SEL_DELIVER;
				last_n       = 1'b0;
				state_n      = S_EMIT;
			end
			S_EMIT: begin
				if (out_ready) begin
					state_n = last_q ? S_IDLE : S_CHECK;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			state_q     <= state_n;
			out_valid_q <= (state_n == S_EMIT);
			last_q      <= last_n;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_last  = last_q;

endmodule

`default_nettype wire

[src/selective_repeat_receive_window.sv]
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Receiver side of a sliding-window transfer. One packet descriptor is taken
// at a time on pkt and answered on res with zero or more results, the last
// one flagged by last_of_run. An ignored descriptor is dropped, one answered
// by a single ack or reject is classified and output, and an in-order data
// packet is stored and releases its run of stored slots, each release with a
// window check, one registered read of the slot RAM and an output step, and
// then ends with an ack. The slot length and tag live in a WINDOW-deep RAM
// addressed as a ring from the window head; received marks are flip-flops
// cleared by reset and by a good start packet. The register port cfg is
// always ready; the user must write it only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_receive_window #(
	parameter int WINDOW = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	srrw_pkt_if.sink    pkt,
	srrw_res_if.source  res,
	srrw_cfg_if.sink    cfg
);
	import srrw_pkg::*;

	`include "assert_macros.svh"

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	assign cfg.ready = 1'b1;

	srrw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pkt.valid),
		.in_ready (pkt.ready),
		.out_valid(res.valid),
		.out_ready(res.ready),
		.out_last (res.last_of_run),
		.sts      (sts),
		.cmd      (cmd)
	);

	srrw_dp #(
		.WINDOW(WINDOW)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg.valid),
		.cfg_idx (cfg.index),
		.cfg_data(cfg.data),
		.in_kind (pkt.packet_kind),
		.in_good (pkt.checksum_good),
		.in_seq  (pkt.sequence_number),
		.in_len  (pkt.payload_length),
		.in_tag  (pkt.payload_tag),
		.cmd     (cmd),
		.sts     (sts),
		.res_kind(res.result_kind),
		.res_ack (res.ack_number),
		.res_tag (res.deliver_tag),
		.res_len (res.deliver_length),
		.res_done(res.session_done)
	);

	`CHK_NEVER(a_no_accept_while_out, pkt.ready && res.valid, "input taken with result pending")
	`CHK_PROP(a_store_needs_open, cmd.store |-> sts.open, "slot store on closed session")
	`CHK_PROP(a_pop_needs_mark, cmd.pop |-> sts.can_pop, "release of unmarked slot")
	`CHK_PROP(a_deliver_not_last, (res.valid && res.result_kind == RES_DELIVER) |-> !res.last_of_run, "delivery flagged last")

endmodule

`default_nettype wire
